// ----- hw/rtl/rlt_pkg.sv -----
// Shared types, field widths, register indexes and codes for the redo log
// transaction tracker. No dependencies; every other file in hw/rtl uses it.
package rlt_pkg;

    localparam int ACTION_W    = 2;
    localparam int BLOCK_W     = 32;
    localparam int STATUS_W    = 4;
    localparam int COUNT_W     = 6;
    localparam int LOG_BLK_W   = 16;
    localparam int RESERVE_W   = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int DEFAULT_TABLE_DEPTH = 32;

    // Open-op and entry counters saturate here
    localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

    localparam logic [LOG_BLK_W-1:0] LOG_BLOCKS_RST = 16'd33;
    localparam logic [RESERVE_W-1:0] OP_RESERVE_RST = 6'd10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_BLOCKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OP_RESERVE = 2'd1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_BEGIN       = 2'd0,
        ACT_END         = 2'd1,
        ACT_WRITE       = 2'd2,
        ACT_COMMIT_DONE = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED      = 4'd0,
        ST_WAIT         = 4'd1,
        ST_ABSORBED     = 4'd2,
        ST_APPENDED     = 4'd3,
        ST_TOO_BIG      = 4'd4,
        ST_OUTSIDE      = 4'd5,
        ST_END_IN_CMT   = 4'd6,
        ST_COMMIT_ENTRY = 4'd7,
        ST_ENDED        = 4'd8,
        ST_CLEARED      = 4'd9
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_SCAN,
        FSM_RESP,
        FSM_EMIT_RD,
        FSM_EMIT_OUT
    } fsm_t;

endpackage

// ----- hw/rtl/rlt_table.sv -----
// Block number table of the redo log tracker: one write port, one read port
// with registered read data. Depends on rlt_pkg for the entry width.
module rlt_table #(
    parameter int DEPTH = rlt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  logic [rlt_pkg::BLOCK_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr,
    output logic [rlt_pkg::BLOCK_W-1:0] rd_data
);

    logic [rlt_pkg::BLOCK_W-1:0] mem [DEPTH];
    logic [rlt_pkg::BLOCK_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // Hold read data until the next read
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/redo_log_transaction_tracker.sv -----
// Top level of the redo log transaction tracker: sequencer, counters and
// result register. Depends on rlt_pkg and rlt_table.
//
// Input (in_valid/in_ready, action, block_number): one transfer per operation;
//   in_ready is high only while the sequencer is idle.
// Output (out_valid/out_ready, status, entry_block, entry_count, last): one
//   result per operation, except the end of the last open operation, which
//   gives one commit entry per logged block with last set on the final one.
// Configuration (cfg_write, cfg_index, cfg_data): write log_blocks (index 0)
//   or op_reserve (index 1) while idle; other indexes are dropped.
// Sequence: begin, end, commit-done and rejected writes pass through the EXEC
//   and RESP states before their result is loaded. A block write that searches
//   the table adds the SCAN state, with one table read and one 32-bit compare
//   per cycle. A commit reads each entry in EMIT_RD, then loads it into the
//   output register in EMIT_OUT.
// Acceptance: the next operation is taken the cycle after the last result is
//   loaded.
// Reset: rst_n clears counters, flags and out_valid and loads the defaults
//   (33 and 10); the table keeps its contents, only entries below the count
//   are read. Stall: a result waits in the output register until taken; the
//   sequencer holds before loading the next one, but idle it takes new input.
module redo_log_transaction_tracker #(
    parameter int TABLE_DEPTH = rlt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_write,
    input  logic [rlt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rlt_pkg::CFG_DATA_W-1:0] cfg_data,
    // operation input
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [rlt_pkg::ACTION_W-1:0]   action,
    input  logic [rlt_pkg::BLOCK_W-1:0]    block_number,
    // result output
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [rlt_pkg::STATUS_W-1:0]   status,
    output logic [rlt_pkg::BLOCK_W-1:0]    entry_block,
    output logic [rlt_pkg::COUNT_W-1:0]    entry_count,
    output logic                           last
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int NEED_W = 14;

    // Sequencer and control state
    rlt_pkg::fsm_t                   state_reg, state_next;
    logic [rlt_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic [rlt_pkg::COUNT_W-1:0]     open_reg, open_next;
    logic                            busy_reg, busy_next;
    logic [rlt_pkg::COUNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                            pend_reg, pend_next;
    rlt_pkg::status_t                resp_reg, resp_next;
    logic [rlt_pkg::LOG_BLK_W-1:0]   log_blocks_reg;
    logic [rlt_pkg::RESERVE_W-1:0]   op_reserve_reg;
    logic                            out_valid_reg, out_valid_next;

    // Payload registers, no reset
    logic [rlt_pkg::ACTION_W-1:0]    action_reg;
    logic [rlt_pkg::BLOCK_W-1:0]     blk_reg;
    logic [rlt_pkg::STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [rlt_pkg::BLOCK_W-1:0]     out_block_reg, out_block_next;
    logic [rlt_pkg::COUNT_W-1:0]     out_count_reg, out_count_next;
    logic                            out_last_reg, out_last_next;
    logic                            out_load;

    // Table interface
    logic                            tbl_wr_en;
    logic                            tbl_rd_en;
    logic [rlt_pkg::BLOCK_W-1:0]     tbl_rd_data;

    logic                            in_fire;
    logic                            out_free;
    logic [NEED_W-1:0]               need;
    logic                            begin_wait;
    logic                            table_full;
    logic                            issue;
    logic                            hit;
    logic                            emit_last;

    assign in_ready = (state_reg == rlt_pkg::FSM_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Admission: logged + (open + 1) * reserve against the table depth
    assign need = NEED_W'(count_reg)
                + (NEED_W'(open_reg) + NEED_W'(1)) * NEED_W'(op_reserve_reg);
    assign begin_wait = busy_reg || (open_reg == rlt_pkg::COUNT_MAX)
                     || (need > NEED_W'(TABLE_DEPTH));

    assign table_full = (7'(count_reg) >= 7'(TABLE_DEPTH))
                     || ((17'(count_reg) + 17'd1) >= 17'(log_blocks_reg))
                     || (count_reg == rlt_pkg::COUNT_MAX);

    // Search: issue one read per cycle, compare the previous read's data
    assign issue     = (rd_idx_reg < count_reg);
    assign hit       = pend_reg && (tbl_rd_data == blk_reg);
    assign emit_last = ((rd_idx_reg + 6'd1) == count_reg);

    rlt_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (blk_reg),
        .rd_en   (tbl_rd_en),
        .rd_addr (rd_idx_reg[IDX_W-1:0]),
        .rd_data (tbl_rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        open_next       = open_reg;
        busy_next       = busy_reg;
        rd_idx_next     = rd_idx_reg;
        pend_next       = pend_reg;
        resp_next       = resp_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_load        = 1'b0;
        out_status_next = out_status_reg;
        out_block_next  = out_block_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        tbl_wr_en       = 1'b0;
        tbl_rd_en       = 1'b0;

        case (state_reg)
            rlt_pkg::FSM_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = rlt_pkg::FSM_EXEC;
                end
            end

            rlt_pkg::FSM_EXEC:
            begin
                state_next = rlt_pkg::FSM_RESP;
                case (action_reg)
                    rlt_pkg::ACT_BEGIN:
                    begin
                        if (begin_wait)
                        begin
                            resp_next = rlt_pkg::ST_WAIT;
                        end
                        else
                        begin
                            open_next = open_reg + 6'd1;
                            resp_next = rlt_pkg::ST_GRANTED;
                        end
                    end
                    rlt_pkg::ACT_END:
                    begin
                        if (busy_reg)
                        begin
                            resp_next = rlt_pkg::ST_END_IN_CMT;
                        end
                        else if (open_reg == '0)
                        begin
                            resp_next = rlt_pkg::ST_OUTSIDE;
                        end
                        else if (open_reg != 6'd1)
                        begin
                            open_next = open_reg - 6'd1;
                            resp_next = rlt_pkg::ST_ENDED;
                        end
                        else
                        begin
                            // Last op closed: start the commit
                            open_next = '0;
                            busy_next = 1'b1;
                            resp_next = rlt_pkg::ST_COMMIT_ENTRY;
                            if (count_reg != '0)
                            begin
                                rd_idx_next = '0;
                                state_next  = rlt_pkg::FSM_EMIT_RD;
                            end
                        end
                    end
                    rlt_pkg::ACT_WRITE:
                    begin
                        if (table_full)
                        begin
                            resp_next = rlt_pkg::ST_TOO_BIG;
                        end
                        else if (open_reg == '0)
                        begin
                            resp_next = rlt_pkg::ST_OUTSIDE;
                        end
                        else
                        begin
                            rd_idx_next = '0;
                            pend_next   = 1'b0;
                            state_next  = rlt_pkg::FSM_SCAN;
                        end
                    end
                    default:
                    begin
                        // Commit done; a no-op when no commit is running
                        if (busy_reg)
                        begin
                            count_next = '0;
                            busy_next  = 1'b0;
                        end
                        resp_next = rlt_pkg::ST_CLEARED;
                    end
                endcase
            end

            rlt_pkg::FSM_SCAN:
            begin
                if (hit)
                begin
                    resp_next  = rlt_pkg::ST_ABSORBED;
                    state_next = rlt_pkg::FSM_RESP;
                end
                else if (!issue && !pend_reg)
                begin
                    // Not found: append at the end of the table
                    tbl_wr_en  = 1'b1;
                    count_next = count_reg + 6'd1;
                    resp_next  = rlt_pkg::ST_APPENDED;
                    state_next = rlt_pkg::FSM_RESP;
                end
                else
                begin
                    tbl_rd_en   = issue;
                    pend_next   = issue;
                    rd_idx_next = rd_idx_reg + {5'd0, issue};
                end
            end

            rlt_pkg::FSM_RESP:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_valid_next  = 1'b1;
                    out_status_next = resp_reg;
                    out_block_next  = '0;
                    out_count_next  = count_reg;
                    out_last_next   = 1'b1;
                    state_next      = rlt_pkg::FSM_IDLE;
                end
            end

            rlt_pkg::FSM_EMIT_RD:
            begin
                tbl_rd_en  = 1'b1;
                state_next = rlt_pkg::FSM_EMIT_OUT;
            end

            rlt_pkg::FSM_EMIT_OUT:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_valid_next  = 1'b1;
                    out_status_next = rlt_pkg::ST_COMMIT_ENTRY;
                    out_block_next  = tbl_rd_data;
                    out_count_next  = count_reg;
                    out_last_next   = emit_last;
                    if (emit_last)
                    begin
                        state_next = rlt_pkg::FSM_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + 6'd1;
                        state_next  = rlt_pkg::FSM_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = rlt_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rlt_pkg::FSM_IDLE;
            count_reg      <= '0;
            open_reg       <= '0;
            busy_reg       <= 1'b0;
            rd_idx_reg     <= '0;
            pend_reg       <= 1'b0;
            resp_reg       <= rlt_pkg::ST_GRANTED;
            out_valid_reg  <= 1'b0;
            log_blocks_reg <= rlt_pkg::LOG_BLOCKS_RST;
            op_reserve_reg <= rlt_pkg::OP_RESERVE_RST;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            open_reg      <= open_next;
            busy_reg      <= busy_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            resp_reg      <= resp_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write && (cfg_index == rlt_pkg::CFG_LOG_BLOCKS))
            begin
                log_blocks_reg <= cfg_data;
            end
            if (cfg_write && (cfg_index == rlt_pkg::CFG_OP_RESERVE))
            begin
                op_reserve_reg <= cfg_data[rlt_pkg::RESERVE_W-1:0];
            end
        end
    end

    // Capture the operation on transfer; load results when the slot frees
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            action_reg <= action;
            blk_reg    <= block_number;
        end
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_block_reg  <= out_block_next;
            out_count_reg  <= out_count_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign entry_block = out_block_reg;
    assign entry_count = out_count_reg;
    assign last        = out_last_reg;

endmodule

// ----- tb/rlt_tb_pkg.sv -----
`timescale 1ns / 1ps
// Scoreboard for the redo log transaction tracker testbench: an operation-level
// predictor of the log table and a queue of awaited results. Depends on rlt_pkg.
package rlt_tb_pkg;

    import rlt_pkg::*;

    localparam int DEPTH = DEFAULT_TABLE_DEPTH;

    typedef struct packed {
        status_t             status;
        logic [BLOCK_W-1:0]  blk;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } tracker_result_t;

    class log_tracker_scoreboard;

        // predicted tracker state
        logic [BLOCK_W-1:0] logged_blocks [DEPTH];
        int unsigned        n_logged;
        int unsigned        n_open;
        bit                 committing;
        int unsigned        log_blocks;
        int unsigned        op_reserve;

        tracker_result_t    awaited_results [$];
        int                 errors;

        function new();
            n_logged   = 0;
            n_open     = 0;
            committing = 0;
            log_blocks = LOG_BLOCKS_RST;
            op_reserve = OP_RESERVE_RST;
            errors     = 0;
        endfunction

        function int awaited();
            return awaited_results.size();
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_LOG_BLOCKS)
                log_blocks = data[LOG_BLK_W-1:0];
            else if (idx == CFG_OP_RESERVE)
                op_reserve = data[RESERVE_W-1:0];
        endfunction

        function void add_awaited(status_t st, logic [BLOCK_W-1:0] blk, logic lst);
            tracker_result_t r;
            r.status = st;
            r.blk    = blk;
            r.count  = n_logged[COUNT_W-1:0];
            r.last   = lst;
            awaited_results.push_back(r);
        endfunction

        // Advance the predicted state by one accepted operation and queue its results.
        function void note_operation(action_t op, logic [BLOCK_W-1:0] blk);
            int unsigned need;
            int unsigned i;
            case (op)
                ACT_BEGIN:
                begin
                    need = n_logged + (n_open + 1) * op_reserve;
                    if (committing || n_open >= COUNT_MAX || need > DEPTH)
                        add_awaited(ST_WAIT, '0, 1'b1);
                    else
                    begin
                        n_open++;
                        add_awaited(ST_GRANTED, '0, 1'b1);
                    end
                end
                ACT_END:
                begin
                    if (committing)
                        add_awaited(ST_END_IN_CMT, '0, 1'b1);
                    else if (n_open == 0)
                        add_awaited(ST_OUTSIDE, '0, 1'b1);
                    else
                    begin
                        n_open--;
                        if (n_open != 0)
                            add_awaited(ST_ENDED, '0, 1'b1);
                        else
                        begin
                            committing = 1;
                            if (n_logged == 0)
                                add_awaited(ST_COMMIT_ENTRY, '0, 1'b1);
                            else
                                for (i = 0; i < n_logged; i++)
                                    add_awaited(ST_COMMIT_ENTRY, logged_blocks[i],
                                                i + 1 == n_logged);
                        end
                    end
                end
                ACT_WRITE:
                begin
                    // the full-table check wins even over a block that would be absorbed
                    if (n_logged >= DEPTH || n_logged + 1 >= log_blocks || n_logged >= COUNT_MAX)
                        add_awaited(ST_TOO_BIG, '0, 1'b1);
                    else if (n_open == 0)
                        add_awaited(ST_OUTSIDE, '0, 1'b1);
                    else
                    begin
                        for (i = 0; i < n_logged; i++)
                            if (logged_blocks[i] == blk)
                                break;
                        if (i < n_logged)
                            add_awaited(ST_ABSORBED, '0, 1'b1);
                        else
                        begin
                            logged_blocks[n_logged] = blk;
                            n_logged++;
                            add_awaited(ST_APPENDED, '0, 1'b1);
                        end
                    end
                end
                default:
                begin
                    if (committing)
                    begin
                        n_logged   = 0;
                        committing = 0;
                    end
                    add_awaited(ST_CLEARED, '0, 1'b1);
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [STATUS_W-1:0] st, logic [BLOCK_W-1:0] blk,
                          logic [COUNT_W-1:0] cnt, logic lst);
            tracker_result_t want;
            if (awaited_results.size() == 0)
                report_mismatch($sformatf("result with none awaited: status %0d", st));
            else
            begin
                want = awaited_results.pop_front();
                if (st !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", st, want.status));
                if (blk !== want.blk)
                    report_mismatch($sformatf("entry_block %h, want %h", blk, want.blk));
                if (cnt !== want.count)
                    report_mismatch($sformatf("entry_count %0d, want %0d", cnt, want.count));
                if (lst !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", lst, want.last));
            end
        endtask

    endclass

endpackage

// ----- tb/redo_log_transaction_tracker_tb.sv -----
`timescale 1ns / 1ps
// Top-level testbench of the redo log transaction tracker: drives operations,
// register writes and output stalls. Depends on rlt_pkg, rlt_tb_pkg and the RTL.
module redo_log_transaction_tracker_tb;

    import rlt_pkg::*;
    import rlt_tb_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [ACTION_W-1:0]   action;
    logic [BLOCK_W-1:0]    block_number;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [BLOCK_W-1:0]    entry_block;
    logic [COUNT_W-1:0]    entry_count;
    logic                  last;

    log_tracker_scoreboard sb;

    // idle rates in percent of cycles, changed per phase
    int send_idle_pct = 10;
    int recv_idle_pct = 74;
    int ops_sent      = 0;

    redo_log_transaction_tracker #(
        .TABLE_DEPTH(DEFAULT_TABLE_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .block_number (block_number),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .entry_block  (entry_block),
        .entry_count  (entry_count),
        .last         (last)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver: stall at random on each falling edge, at the current idle rate.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Check every result transfer against the oldest awaited result.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(status, entry_block, entry_count, last);
    end

    // Hard stop in case the block hangs; far beyond the slowest correct run.
    initial
    begin
        #8000000;
        $display("Mismatches found");
        $finish;
    end

    // Present one operation and hold it until the transfer. Entered and left at a
    // falling edge, with valid left high so that back-to-back items need no toggle.
    task automatic send_op(action_t op, logic [BLOCK_W-1:0] blk);
        int  gap;
        bit  pause;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        // hold off now and then until the block has answered everything so far
        pause = ($urandom_range(0, 99) < 3) || (ops_sent == 40);
        if (pause && gap == 0)
            gap = 1;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
            while (pause && sb.awaited() > 0)
                @(negedge clk);
        end
        in_valid     <= 1'b1;
        action       <= op;
        block_number <= blk;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_operation(op, blk);
        ops_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every awaited result has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.awaited() > 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Write one register; only called while the block is idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_register(idx, data);
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // One well-formed transaction with random content: begins, block writes with
    // some repeats, a matching number of ends and usually a commit-done. Stray
    // operations of any kind are mixed into the writes, and now and then an extra
    // end or a missing commit-done breaks the pattern.
    task automatic run_txn(bit long_run);
        logic [BLOCK_W-1:0] used [$];
        logic [BLOCK_W-1:0] blk;
        int                 n_begin;
        int                 n_write;
        int                 k;
        n_begin = $urandom_range(1, 3);
        n_write = long_run ? 36 : $urandom_range(0, 8);
        for (k = 0; k < n_begin; k++)
            send_op(ACT_BEGIN, $urandom());
        for (k = 0; k < n_write; k++)
        begin
            if (used.size() > 0 && $urandom_range(0, 99) < (long_run ? 5 : 30))
                blk = used[$urandom_range(0, used.size() - 1)];
            else
            begin
                // keep some numbers small so that absorption hits across transactions
                blk = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom();
                used.push_back(blk);
            end
            if ($urandom_range(0, 9) == 0)
                send_op(action_t'($urandom_range(0, 3)), $urandom());
            send_op(ACT_WRITE, blk);
        end
        for (k = 0; k < n_begin; k++)
            send_op(ACT_END, $urandom());
        if ($urandom_range(0, 3) == 0)
            send_op(ACT_END, $urandom());
        if ($urandom_range(0, 9) != 0)
            send_op(ACT_COMMIT_DONE, $urandom());
    endtask

    initial
    begin
        int k;
        sb           = new();
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = CFG_LOG_BLOCKS;
        cfg_data     = '0;
        in_valid     = 1'b0;
        action       = ACT_BEGIN;
        block_number = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset settings (33 blocks, reserve 10).
        send_op(ACT_END, '0);             // end with nothing open
        send_op(ACT_WRITE, 32'd5);        // write outside a transaction
        send_op(ACT_COMMIT_DONE, '0);     // commit-done while idle
        send_op(ACT_BEGIN, '0);
        send_op(ACT_BEGIN, '0);
        send_op(ACT_BEGIN, '0);           // reserves 30 of 32
        send_op(ACT_BEGIN, '1);           // reserve exceeded: wait
        send_op(ACT_WRITE, 32'h0000_0000);
        send_op(ACT_WRITE, 32'hFFFF_FFFF);
        send_op(ACT_WRITE, 32'h0000_0000); // absorbed
        send_op(ACT_WRITE, 32'hA5A5_5A5A);
        send_op(ACT_END, '0);
        send_op(ACT_END, '0);
        send_op(ACT_END, '0);             // last end: commit list of three
        send_op(ACT_BEGIN, '0);           // begin during commit: wait
        send_op(ACT_END, '0);             // end during commit
        send_op(ACT_WRITE, 32'd7);        // write during commit: outside
        send_op(ACT_COMMIT_DONE, '1);
        send_op(ACT_BEGIN, '0);
        send_op(ACT_END, '0);             // empty commit
        send_op(ACT_COMMIT_DONE, '0);
        drain_results();

        // Tiny log area: the second write is rejected as too big, even though
        // the same block is already logged.
        write_reg(CFG_LOG_BLOCKS, 16'd2);
        write_reg(CFG_OP_RESERVE, 16'd1);
        send_op(ACT_BEGIN, '0);
        send_op(ACT_WRITE, 32'd1);
        send_op(ACT_WRITE, 32'd1);
        send_op(ACT_END, '0);
        send_op(ACT_COMMIT_DONE, '0);
        drain_results();

        // Largest log area, reserve of 1: a long transaction fills the table.
        write_reg(CFG_LOG_BLOCKS, 16'hFFFF);
        run_txn(1'b1);
        while (ops_sent < 72)
            run_txn(1'b0);
        drain_results();

        // Swap the idle rates; a reserve of 32 admits one open operation at a time.
        send_idle_pct = 74;
        recv_idle_pct = 10;
        write_reg(CFG_LOG_BLOCKS, 16'd20);
        write_reg(CFG_OP_RESERVE, 16'd32);
        write_reg(2'd2, CFG_DATA_W'($urandom()));   // unused indexes are dropped
        write_reg(2'd3, CFG_DATA_W'($urandom()));
        while (ops_sent < 82)
            run_txn(1'b0);
        drain_results();

        // No idling from here on. A zero reserve lets begins pile up until the
        // open-operation count saturates; close any running commit first.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_LOG_BLOCKS, 16'd12);
        write_reg(CFG_OP_RESERVE, 16'd0);
        send_op(ACT_COMMIT_DONE, $urandom());
        for (k = 0; k < 64; k++)
            send_op(ACT_BEGIN, $urandom());
        for (k = 0; k < 2; k++)
            send_op(ACT_WRITE, $urandom());
        for (k = 0; k < 63; k++)
            send_op(ACT_END, $urandom());
        send_op(ACT_COMMIT_DONE, $urandom());
        drain_results();

        // Zero log area and all-ones reserve: every begin waits, every write is too big.
        write_reg(CFG_LOG_BLOCKS, 16'd0);
        write_reg(CFG_OP_RESERVE, 16'hFFFF);
        run_txn(1'b0);
        drain_results();

        // Back to the reset values.
        write_reg(CFG_LOG_BLOCKS, 16'd33);
        write_reg(CFG_OP_RESERVE, 16'd10);
        run_txn(1'b0);
        drain_results();

        // allow a full commit list worth of cycles for any stray result
        repeat (70) @(negedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
